FILE: sv/collision_impulse_response_macros.svh
// Assertion macros for the collision impulse response block.
// Used by the port checker; needs clk_i and rst_ni in scope.
`ifndef COLLISION_IMPULSE_RESPONSE_MACROS_SVH
`define COLLISION_IMPULSE_RESPONSE_MACROS_SVH

// same-cycle implication
`define CIR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CIR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cir_pkg.sv
// Shared types, stage map and helpers for the collision impulse response block.
// No dependencies.
package cir_pkg;

  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  localparam int ELASTIC_FRAC = 14;
  localparam int ELASTIC_BITS = 15;
  localparam int SHARE_BITS   = FRAC_BITS + 1;

  // front pipeline stage map
  localparam int SHARE_FIRST = 2;
  localparam int DIV_STEPS   = SHARE_BITS;
  localparam int SQ_FIRST    = 3;
  localparam int SQ_STEPS    = WORD_BITS;
  localparam int LEN_STG     = SQ_FIRST + SQ_STEPS;
  localparam int ND_FIRST    = LEN_STG + 1;
  localparam int FRONT_LAST  = ND_FIRST + DIV_STEPS - 1;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        mag_t;
  typedef logic [SHARE_BITS-1:0]       frac_t;
  typedef logic [WORD_BITS+1:0]        rem_t;
  typedef logic [2*WORD_BITS-1:0]      sq_t;
  typedef logic [ELASTIC_BITS-1:0]     elastic_t;

  typedef struct packed {
    mag_t     ma;
    mag_t     mb;
    elastic_t ea;
    elastic_t eb;
    word_t    vax;
    word_t    vay;
    word_t    vbx;
    word_t    vby;
    word_t    sx;
    word_t    sy;
  } cir_in_t;

  typedef struct packed {
    cir_in_t              in;
    logic                 degen;
    logic [WORD_BITS:0]   den;
    rem_t                 ra;
    rem_t                 rb;
    frac_t                m1;
    frac_t                m2;
    sq_t                  sqa;
    sq_t                  sqb;
    sq_t                  rx;
    sq_t                  root;
    mag_t                 len;
    rem_t                 nrx;
    rem_t                 nry;
    frac_t                qx;
    frac_t                qy;
  } front_t;

  function automatic mag_t mag_of(input word_t x);
    return x[WORD_BITS-1] ? mag_t'(-x) : mag_t'(x);
  endfunction

  function automatic sq_t sq_bit(input int j);
    sq_t b;
    b = '0;
    if (j >= 0 && j < SQ_STEPS) b[2*WORD_BITS-2-2*j] = 1'b1;
    return b;
  endfunction

  function automatic word_t sat_word(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return word_t'(hi[WORD_BITS-1:0]);
    if (v < lo) return word_t'(lo[WORD_BITS-1:0]);
    return word_t'(v[WORD_BITS-1:0]);
  endfunction

endpackage

FILE: sv/cir_front.sv
// Front pipeline: mass shares, separation length (square root) and unit normal.
// One digit per stage for each divider and the root. Depends on cir_pkg.
module cir_front import cir_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  logic    in_vld_i,
  input  cir_in_t in_i,
  output logic    out_vld_o,
  output front_t  out_o
);

  front_t                stg_d [FRONT_LAST+1];
  front_t                stg_q [FRONT_LAST+1];
  logic [FRONT_LAST:0]   vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[FRONT_LAST-1:0], in_vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i <= FRONT_LAST; i++) stg_q[i] <= stg_d[i];
    end
  end

  always_comb begin
    stg_d[0]    = '0;
    stg_d[0].in = in_i;
  end

  for (genvar k = 1; k <= FRONT_LAST; k++) begin : g_stg
    always_comb begin
      mag_t                 ux;
      mag_t                 uy;
      rem_t                 dn;
      rem_t                 nl;
      rem_t                 r;
      sq_t                  bit_v;
      logic [2*WORD_BITS:0] trial;
      stg_d[k] = stg_q[k-1];
      ux    = mag_of(stg_q[k-1].in.sx);
      uy    = mag_of(stg_q[k-1].in.sy);
      dn    = {1'b0, stg_q[k-1].den};
      nl    = {2'b0, stg_q[k-1].len};
      bit_v = sq_bit(k - SQ_FIRST);
      trial = {1'b0, stg_q[k-1].root} + {1'b0, bit_v};

      if (k == 1) begin
        stg_d[k].den   = {1'b0, stg_q[k-1].in.ma} + {1'b0, stg_q[k-1].in.mb};
        stg_d[k].degen = (stg_d[k].den == '0) ||
                         (stg_q[k-1].in.sx == '0 && stg_q[k-1].in.sy == '0);
        stg_d[k].ra    = rem_t'(stg_q[k-1].in.ma);
        stg_d[k].rb    = rem_t'(stg_q[k-1].in.mb);
        stg_d[k].m1    = '0;
        stg_d[k].m2    = '0;
        stg_d[k].sqa   = sq_t'(ux) * sq_t'(ux);
        stg_d[k].sqb   = sq_t'(uy) * sq_t'(uy);
      end

      if (k == 2) begin
        stg_d[k].rx   = stg_q[k-1].sqa + stg_q[k-1].sqb;
        stg_d[k].root = '0;
      end

      // mass shares: restoring division, one quotient bit per stage
      if (k >= SHARE_FIRST && k < SHARE_FIRST + DIV_STEPS) begin
        r = (stg_q[k-1].ra >= dn) ? stg_q[k-1].ra - dn : stg_q[k-1].ra;
        stg_d[k].ra = r << 1;
        stg_d[k].m1 = {stg_q[k-1].m1[SHARE_BITS-2:0], stg_q[k-1].ra >= dn};
        r = (stg_q[k-1].rb >= dn) ? stg_q[k-1].rb - dn : stg_q[k-1].rb;
        stg_d[k].rb = r << 1;
        stg_d[k].m2 = {stg_q[k-1].m2[SHARE_BITS-2:0], stg_q[k-1].rb >= dn};
      end

      // separation length: one root bit per stage
      if (k >= SQ_FIRST && k < SQ_FIRST + SQ_STEPS) begin
        if ({1'b0, stg_q[k-1].rx} >= trial) begin
          stg_d[k].rx   = stg_q[k-1].rx - trial[2*WORD_BITS-1:0];
          stg_d[k].root = (stg_q[k-1].root >> 1) + bit_v;
        end else begin
          stg_d[k].root = stg_q[k-1].root >> 1;
        end
      end

      if (k == LEN_STG) begin
        stg_d[k].len = (stg_q[k-1].root[WORD_BITS-1:0] == '0) ? mag_t'(1) :
                       stg_q[k-1].root[WORD_BITS-1:0];
        stg_d[k].nrx = rem_t'(ux);
        stg_d[k].nry = rem_t'(uy);
        stg_d[k].qx  = '0;
        stg_d[k].qy  = '0;
      end

      // normal components: magnitude / length, one bit per stage
      if (k >= ND_FIRST && k < ND_FIRST + DIV_STEPS) begin
        r = (stg_q[k-1].nrx >= nl) ? stg_q[k-1].nrx - nl : stg_q[k-1].nrx;
        stg_d[k].nrx = r << 1;
        stg_d[k].qx  = {stg_q[k-1].qx[SHARE_BITS-2:0], stg_q[k-1].nrx >= nl};
        r = (stg_q[k-1].nry >= nl) ? stg_q[k-1].nry - nl : stg_q[k-1].nry;
        stg_d[k].nry = r << 1;
        stg_d[k].qy  = {stg_q[k-1].qy[SHARE_BITS-2:0], stg_q[k-1].nry >= nl};
      end
    end
  end

  assign out_vld_o = vld_q[FRONT_LAST];
  assign out_o     = stg_q[FRONT_LAST];

endmodule

FILE: sv/collision_impulse_response.sv
// Pipeline: 53 front stages for shares, square root and normal division, then 7 product stages.
// Throughput: one transaction per cycle; the whole pipeline holds while a valid output is stalled.
// Reset: rst_ni clears all valid bits asynchronously; payload registers are not reset.
// Depends on cir_pkg and cir_front.
module collision_impulse_response import cir_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mag_t     mass_a_i,
  input  mag_t     mass_b_i,
  input  elastic_t elastic_a_i,
  input  elastic_t elastic_b_i,
  input  word_t    vel_ax_i,
  input  word_t    vel_ay_i,
  input  word_t    vel_bx_i,
  input  word_t    vel_by_i,
  input  word_t    sep_x_i,
  input  word_t    sep_y_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output word_t    pos_delta_ax_o,
  output word_t    pos_delta_ay_o,
  output word_t    pos_delta_bx_o,
  output word_t    pos_delta_by_o,
  output word_t    new_vel_ax_o,
  output word_t    new_vel_ay_o,
  output word_t    new_vel_bx_o,
  output word_t    new_vel_by_o,
  output logic     degenerate_o
);

  localparam int TAIL = 7;
  localparam int PN_W = SHARE_BITS + WORD_BITS;
  localparam int T_W  = WORD_BITS + 3;
  localparam int E_W  = ELASTIC_BITS + 1;
  localparam int PE_W = T_W + E_W;
  localparam int PF_W = PE_W - ELASTIC_FRAC + SHARE_BITS;
  localparam int P_W  = PF_W - FRAC_BITS;
  localparam int W_W  = P_W + SHARE_BITS;
  localparam logic [E_W-1:0] ELASTIC_ONE = E_W'(1) << ELASTIC_FRAC;

  typedef struct packed {
    logic     degen;
    word_t    vax;
    word_t    vay;
    word_t    vbx;
    word_t    vby;
    elastic_t ea;
    elastic_t eb;
    frac_t    m1;
    frac_t    m2;
    frac_t    qx;
    frac_t    qy;
    logic     sxn;
    logic     syn;
    word_t    pdax;
    word_t    pday;
    word_t    pdbx;
    word_t    pdby;
  } carry_t;

  logic            adv;
  cir_in_t         fin;
  logic            f_vld;
  front_t          f;

  carry_t          c_d [TAIL];
  carry_t          c_q [TAIL];
  logic [TAIL-1:0] tv_q;

  logic [PN_W-1:0]        pn_d [4];
  logic [PN_W-1:0]        pn_q [4];
  logic [PN_W-1:0]        dm_d [4];
  logic [PN_W-1:0]        dm_q [4];
  logic signed [T_W-1:0]  ta_d, tb_d, ta_q, tb_q;
  logic [T_W-1:0]         d_d, d_q;
  logic [PE_W-1:0]        pe1_d, pe2_d, pe1_q, pe2_q;
  logic [PF_W-1:0]        pf1_d, pf2_d, pf1_q, pf2_q;
  logic [W_W-1:0]         w_d [4];
  logic [W_W-1:0]         w_q [4];
  word_t                  nv_d [4];
  word_t                  nv_q [4];

  // hold everything while a finished result waits downstream
  assign adv        = !(tv_q[TAIL-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_comb begin
    fin.ma  = mass_a_i;
    fin.mb  = mass_b_i;
    fin.ea  = elastic_a_i;
    fin.eb  = elastic_b_i;
    fin.vax = vel_ax_i;
    fin.vay = vel_ay_i;
    fin.vbx = vel_bx_i;
    fin.vby = vel_by_i;
    fin.sx  = sep_x_i;
    fin.sy  = sep_y_i;
  end

  cir_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .in_vld_i  (in_valid_i),
    .in_i      (fin),
    .out_vld_o (f_vld),
    .out_o     (f)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= '0;
    end else if (adv) begin
      tv_q <= {tv_q[TAIL-2:0], f_vld};
    end
  end

  // stage 1: normal * velocity and separation * share products
  always_comb begin
    c_d[0]      = '0;
    c_d[0].degen = f.degen;
    c_d[0].vax  = f.in.vax;
    c_d[0].vay  = f.in.vay;
    c_d[0].vbx  = f.in.vbx;
    c_d[0].vby  = f.in.vby;
    c_d[0].ea   = f.in.ea;
    c_d[0].eb   = f.in.eb;
    c_d[0].m1   = f.m1;
    c_d[0].m2   = f.m2;
    c_d[0].qx   = f.qx;
    c_d[0].qy   = f.qy;
    c_d[0].sxn  = f.in.sx[WORD_BITS-1];
    c_d[0].syn  = f.in.sy[WORD_BITS-1];
    pn_d[0] = PN_W'(f.qx) * PN_W'(mag_of(f.in.vax));
    pn_d[1] = PN_W'(f.qy) * PN_W'(mag_of(f.in.vay));
    pn_d[2] = PN_W'(f.qx) * PN_W'(mag_of(f.in.vbx));
    pn_d[3] = PN_W'(f.qy) * PN_W'(mag_of(f.in.vby));
    dm_d[0] = PN_W'(mag_of(f.in.sx)) * PN_W'(f.m1);
    dm_d[1] = PN_W'(mag_of(f.in.sy)) * PN_W'(f.m1);
    dm_d[2] = PN_W'(mag_of(f.in.sx)) * PN_W'(f.m2);
    dm_d[3] = PN_W'(mag_of(f.in.sy)) * PN_W'(f.m2);
  end

  // stage 2: signed projections and saturated position shifts
  always_comb begin
    logic signed [T_W-1:0] t0, t1, t2, t3;
    logic [PN_W-FRAC_BITS-1:0] m0, m1v, m2v, m3;
    c_d[1] = c_q[0];
    m0  = pn_q[0][PN_W-1:FRAC_BITS];
    m1v = pn_q[1][PN_W-1:FRAC_BITS];
    m2v = pn_q[2][PN_W-1:FRAC_BITS];
    m3  = pn_q[3][PN_W-1:FRAC_BITS];
    t0 = (c_q[0].sxn ^ c_q[0].vax[WORD_BITS-1]) ? -T_W'(m0)  : T_W'(m0);
    t1 = (c_q[0].syn ^ c_q[0].vay[WORD_BITS-1]) ? -T_W'(m1v) : T_W'(m1v);
    t2 = (c_q[0].sxn ^ c_q[0].vbx[WORD_BITS-1]) ? -T_W'(m2v) : T_W'(m2v);
    t3 = (c_q[0].syn ^ c_q[0].vby[WORD_BITS-1]) ? -T_W'(m3)  : T_W'(m3);
    ta_d = t0 + t1;
    tb_d = t2 + t3;
    m0  = dm_q[0][PN_W-1:FRAC_BITS];
    m1v = dm_q[1][PN_W-1:FRAC_BITS];
    m2v = dm_q[2][PN_W-1:FRAC_BITS];
    m3  = dm_q[3][PN_W-1:FRAC_BITS];
    c_d[1].pdax = sat_word(c_q[0].sxn ? -64'(m0)  : 64'(m0));
    c_d[1].pday = sat_word(c_q[0].syn ? -64'(m1v) : 64'(m1v));
    c_d[1].pdbx = sat_word(c_q[0].sxn ? 64'(m2v) : -64'(m2v));
    c_d[1].pdby = sat_word(c_q[0].syn ? 64'(m3)  : -64'(m3));
    if (c_q[0].degen) begin
      c_d[1].pdax = '0;
      c_d[1].pday = '0;
      c_d[1].pdbx = '0;
      c_d[1].pdby = '0;
    end
  end

  // stage 3: closing speed
  always_comb begin
    logic [T_W-1:0] aa, ab;
    c_d[2] = c_q[1];
    aa  = ta_q[T_W-1] ? T_W'(-ta_q) : T_W'(ta_q);
    ab  = tb_q[T_W-1] ? T_W'(-tb_q) : T_W'(tb_q);
    d_d = aa + ab;
  end

  // stage 4: scale by one plus elasticity
  always_comb begin
    c_d[3] = c_q[2];
    pe1_d  = PE_W'(d_q) * PE_W'(ELASTIC_ONE + E_W'(c_q[2].ea));
    pe2_d  = PE_W'(d_q) * PE_W'(ELASTIC_ONE + E_W'(c_q[2].eb));
  end

  // stage 5: scale by mass share
  always_comb begin
    c_d[4] = c_q[3];
    pf1_d  = PF_W'(pe1_q[PE_W-1:ELASTIC_FRAC]) * PF_W'(c_q[3].m1);
    pf2_d  = PF_W'(pe2_q[PE_W-1:ELASTIC_FRAC]) * PF_W'(c_q[3].m2);
  end

  // stage 6: impulse along the normal
  always_comb begin
    logic [P_W-1:0] p1, p2;
    c_d[5] = c_q[4];
    p1 = pf1_q[PF_W-1:FRAC_BITS];
    p2 = pf2_q[PF_W-1:FRAC_BITS];
    w_d[0] = W_W'(c_q[4].qx) * W_W'(p1);
    w_d[1] = W_W'(c_q[4].qy) * W_W'(p1);
    w_d[2] = W_W'(c_q[4].qx) * W_W'(p2);
    w_d[3] = W_W'(c_q[4].qy) * W_W'(p2);
  end

  // stage 7: apply impulse and saturate
  always_comb begin
    logic [W_W-FRAC_BITS-1:0] k0, k1, k2, k3;
    c_d[6] = c_q[5];
    k0 = w_q[0][W_W-1:FRAC_BITS];
    k1 = w_q[1][W_W-1:FRAC_BITS];
    k2 = w_q[2][W_W-1:FRAC_BITS];
    k3 = w_q[3][W_W-1:FRAC_BITS];
    nv_d[0] = sat_word(64'($signed(c_q[5].vax)) + (c_q[5].sxn ? -64'(k0) : 64'(k0)));
    nv_d[1] = sat_word(64'($signed(c_q[5].vay)) + (c_q[5].syn ? -64'(k1) : 64'(k1)));
    nv_d[2] = sat_word(64'($signed(c_q[5].vbx)) + (c_q[5].sxn ? 64'(k2) : -64'(k2)));
    nv_d[3] = sat_word(64'($signed(c_q[5].vby)) + (c_q[5].syn ? 64'(k3) : -64'(k3)));
    if (c_q[5].degen) begin
      nv_d[0] = c_q[5].vax;
      nv_d[1] = c_q[5].vay;
      nv_d[2] = c_q[5].vbx;
      nv_d[3] = c_q[5].vby;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < TAIL; i++) c_q[i] <= c_d[i];
      for (int i = 0; i < 4; i++) begin
        pn_q[i] <= pn_d[i];
        dm_q[i] <= dm_d[i];
        w_q[i]  <= w_d[i];
        nv_q[i] <= nv_d[i];
      end
      ta_q  <= ta_d;
      tb_q  <= tb_d;
      d_q   <= d_d;
      pe1_q <= pe1_d;
      pe2_q <= pe2_d;
      pf1_q <= pf1_d;
      pf2_q <= pf2_d;
    end
  end

  assign out_valid_o    = tv_q[TAIL-1];
  assign pos_delta_ax_o = c_q[TAIL-1].pdax;
  assign pos_delta_ay_o = c_q[TAIL-1].pday;
  assign pos_delta_bx_o = c_q[TAIL-1].pdbx;
  assign pos_delta_by_o = c_q[TAIL-1].pdby;
  assign new_vel_ax_o   = nv_q[0];
  assign new_vel_ay_o   = nv_q[1];
  assign new_vel_bx_o   = nv_q[2];
  assign new_vel_by_o   = nv_q[3];
  assign degenerate_o   = c_q[TAIL-1].degen;

endmodule

FILE: sv/cir_checker.sv
// Port-level checks for collision_impulse_response, bound to the top level.
// Depends on collision_impulse_response_macros.svh and cir_pkg.
`include "collision_impulse_response_macros.svh"

module cir_checker import cir_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_stall_o,
  input logic  out_valid_o,
  input logic  out_stall_i,
  input word_t pos_delta_ax_o,
  input word_t pos_delta_ay_o,
  input word_t pos_delta_bx_o,
  input word_t pos_delta_by_o,
  input word_t new_vel_ax_o,
  input logic  degenerate_o
);

  `CIR_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "output transaction dropped while stalled")
  `CIR_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(new_vel_ax_o) && $stable(degenerate_o), "stalled output changed")
  `CIR_ASSERT_IMP(a_stall_src, in_stall_o, out_valid_o && out_stall_i, "input stalled without output backpressure")
  `CIR_ASSERT_IMP(a_degen_zero, out_valid_o && degenerate_o, pos_delta_ax_o == '0 && pos_delta_ay_o == '0 && pos_delta_bx_o == '0 && pos_delta_by_o == '0, "degenerate contact moved a body")

endmodule

bind collision_impulse_response cir_checker u_cir_checker (.*);
